[rtl/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, checked out of reset
`define KEA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication in the next cycle, checked out of reset
`define KEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/kea_pkg.sv]
// shared types and constants of the key edge and autorepeat unit
`default_nettype none

package kea_pkg;

    localparam int HELD_W       = 64;
    localparam int TIME_W       = 32;
    localparam int BTN_IDX_W    = 6;
    localparam int BTN_FIELD_W  = 30;
    localparam int SLOW_MASK_W  = 5;
    localparam int CFG_SLOTS    = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTONS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK    = 3'd4;

    // register reset values (1 tick = 1 ms)
    localparam logic [TIME_W-1:0]      DELAY_RST   = 32'd400;
    localparam logic [TIME_W-1:0]      FAST_RST    = 32'd100;
    localparam logic [TIME_W-1:0]      SLOW_RST    = 32'd200;
    localparam logic [BTN_FIELD_W-1:0] BUTTONS_RST = 30'd0;
    localparam logic [SLOW_MASK_W-1:0] MASK_RST    = 5'd12;

    typedef struct packed {
        logic [TIME_W-1:0]      delay_ticks;
        logic [TIME_W-1:0]      fast_period_ticks;
        logic [TIME_W-1:0]      slow_period_ticks;
        logic [BTN_FIELD_W-1:0] channel_buttons;
        logic [SLOW_MASK_W-1:0] slow_mask;
    } kea_cfg_t;

    typedef struct packed {
        logic              take;
        logic              is_held;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] period;
    } kea_chan_ctl_t;

endpackage

`default_nettype wire

[rtl/kea_in_if.sv]
// frame channel: held buttons and timestamp
`default_nettype none

interface kea_in_if;
    logic                          valid;
    logic                          ready;
    logic [kea_pkg::HELD_W-1:0]    held;
    logic [kea_pkg::TIME_W-1:0]    now;

    modport source (output valid, output held, output now, input ready);
    modport sink   (input valid, input held, input now, output ready);
endinterface

`default_nettype wire

[rtl/kea_out_if.sv]
// result channel: pressed events
`default_nettype none

interface kea_out_if;
    logic                          valid;
    logic                          ready;
    logic [kea_pkg::HELD_W-1:0]    pressed;

    modport source (output valid, output pressed, input ready);
    modport sink   (input valid, input pressed, output ready);
endinterface

`default_nettype wire

[rtl/kea_cfg_if.sv]
// configuration write channel
`default_nettype none

interface kea_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [kea_pkg::CFG_IDX_W-1:0]    index;
    logic [kea_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/kea_cfg_regs.sv]
// configuration register file
`default_nettype none

module kea_cfg_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    kea_cfg_if.sink           cfg,
    output kea_pkg::kea_cfg_t regs
);

    kea_pkg::kea_cfg_t cfg_reg;
    kea_pkg::kea_cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                kea_pkg::REG_DELAY:   cfg_next.delay_ticks       = cfg.data;
                kea_pkg::REG_FAST:    cfg_next.fast_period_ticks = cfg.data;
                kea_pkg::REG_SLOW:    cfg_next.slow_period_ticks = cfg.data;
                kea_pkg::REG_BUTTONS:
                    cfg_next.channel_buttons = cfg.data[kea_pkg::BTN_FIELD_W-1:0];
                kea_pkg::REG_MASK:
                    cfg_next.slow_mask = cfg.data[kea_pkg::SLOW_MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delay_ticks       <= kea_pkg::DELAY_RST;
            cfg_reg.fast_period_ticks <= kea_pkg::FAST_RST;
            cfg_reg.slow_period_ticks <= kea_pkg::SLOW_RST;
            cfg_reg.channel_buttons   <= kea_pkg::BUTTONS_RST;
            cfg_reg.slow_mask         <= kea_pkg::MASK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[rtl/kea_channel.sv]
// one autorepeat channel: phase and delay and repeat timers
`default_nettype none

module kea_channel (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire kea_pkg::kea_chan_ctl_t ctl,
    output logic                        fire
);

    localparam logic [1:0] PH_INACTIVE = 2'd0;
    localparam logic [1:0] PH_DELAY    = 2'd1;
    localparam logic [1:0] PH_REPEAT   = 2'd2;

    logic [1:0]                 phase_reg;
    logic [1:0]                 phase_next;
    logic [kea_pkg::TIME_W-1:0] dref_reg;
    logic [kea_pkg::TIME_W-1:0] dref_next;
    logic [kea_pkg::TIME_W-1:0] rref_reg;
    logic [kea_pkg::TIME_W-1:0] rref_next;
    logic [kea_pkg::TIME_W-1:0] delay_elapsed;
    logic [kea_pkg::TIME_W-1:0] repeat_elapsed;

    // wrapping differences
    assign delay_elapsed  = ctl.now - dref_reg;
    assign repeat_elapsed = ctl.now - rref_reg;

    always_comb
    begin
        phase_next = phase_reg;
        dref_next  = dref_reg;
        rref_next  = rref_reg;
        fire       = 1'b0;
        if (ctl.take)
        begin
            if (!ctl.is_held)
            begin
                phase_next = PH_INACTIVE;
            end
            else
            begin
                case (phase_reg)
                    PH_DELAY:
                    begin
                        if (delay_elapsed >= ctl.delay)
                        begin
                            dref_next  = ctl.now;
                            phase_next = PH_REPEAT;
                        end
                    end
                    PH_REPEAT:
                    begin
                        if (repeat_elapsed >= ctl.period)
                        begin
                            rref_next = ctl.now;
                            fire      = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_DELAY;
                        dref_next  = ctl.now;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_INACTIVE;
            dref_reg  <= '0;
            rref_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            dref_reg  <= dref_next;
            rref_reg  <= rref_next;
        end
    end

endmodule

`default_nettype wire

[rtl/key_edge_and_autorepeat_unit.sv]
// top level of the key edge and autorepeat unit
//
// usage
//   frame  : one transfer per frame, carrying the held button vector and a
//            tick timestamp (wraps modulo 2^32)
//   result : one transfer per frame, carrying the pressed vector: new presses
//            (held now, not held last frame) or'ed with autorepeat events
//   cfg    : register writes (delay, fast period, slow period, channel
//            buttons, slow mask); always ready, write only while idle
// timing
//   the result is registered: result valid rises in the cycle after the frame
//   transfer; one frame per cycle sustained while results are taken; the
//   channel timers and the edge mask settle combinationally between the frame
//   handshake and the result register
// reset
//   previous held vector, channel phases and timer references clear to zero,
//   registers take their default values, result channel goes empty
// stall
//   a waiting result holds its register; the frame channel stays ready while
//   the result is taken in the same cycle, so a stalled receiver stops
//   intake after one pending result
`default_nettype none

`include "assert_macros.svh"

module key_edge_and_autorepeat_unit #(
    parameter int BUTTONS  = 64,
    parameter int CHANNELS = 5
) (
    input  wire logic clk,
    input  wire logic rst_n,
    kea_in_if.sink    frame,
    kea_out_if.source result,
    kea_cfg_if.sink   cfg
);

    localparam int HW = kea_pkg::HELD_W;
    localparam int IW = kea_pkg::BTN_IDX_W;

    // buttons at or above BUTTONS never count as held
    localparam logic [HW-1:0] BUTTON_MASK = {HW{1'b1}} >> (HW - BUTTONS);

    kea_pkg::kea_cfg_t       regs;
    kea_pkg::kea_chan_ctl_t  chan_ctl [CHANNELS];
    logic [IW-1:0]           chan_idx [CHANNELS];
    logic [CHANNELS-1:0]     chan_slow;
    logic [CHANNELS-1:0]     chan_fire;

    logic                    take;
    logic [HW-1:0]           held_m;
    logic [HW-1:0]           repeat_hits;
    logic [HW-1:0]           pressed_next;

    logic [HW-1:0]           prev_held_reg;
    logic                    out_valid_reg;
    logic [HW-1:0]           out_pressed_reg;

    // configuration registers
    kea_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // the frame moves whenever the result register is empty or being drained
    assign frame.ready = !out_valid_reg || result.ready;
    assign take        = frame.valid && frame.ready;
    assign held_m      = frame.held & BUTTON_MASK;

    // repeat channels; those past the packed register fields watch button 0
    // at the fast period
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        if (c < kea_pkg::CFG_SLOTS)
        begin : g_cfg
            assign chan_idx[c]  = regs.channel_buttons[c*IW +: IW];
            assign chan_slow[c] = regs.slow_mask[c];
        end
        else
        begin : g_zero
            assign chan_idx[c]  = '0;
            assign chan_slow[c] = 1'b0;
        end

        assign chan_ctl[c].take    = take;
        assign chan_ctl[c].is_held = held_m[chan_idx[c]];
        assign chan_ctl[c].now     = frame.now;
        assign chan_ctl[c].delay   = regs.delay_ticks;
        assign chan_ctl[c].period  = chan_slow[c] ? regs.slow_period_ticks
                                                  : regs.fast_period_ticks;

        kea_channel u_chan (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (chan_ctl[c]),
            .fire  (chan_fire[c])
        );
    end

    // channels sharing a button merge their events
    always_comb
    begin
        repeat_hits = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (chan_fire[c])
            begin
                repeat_hits = repeat_hits | (HW'(1) << chan_idx[c]);
            end
        end
    end

    assign pressed_next = ((held_m & ~prev_held_reg) | repeat_hits) & BUTTON_MASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_held_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                prev_held_reg <= held_m;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each frame transfer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_pressed_reg <= pressed_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.pressed = out_pressed_reg;

    // checks
    `KEA_ASSERT_NEXT(a_frame_gives_result, clk, rst_n, take, out_valid_reg,
        "frame transfer did not load a result")
    `KEA_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !out_valid_reg, frame.ready,
        "frame stalled with an empty result register")
    `KEA_ASSERT_SAME(a_pressed_in_range, clk, rst_n, out_valid_reg,
        (out_pressed_reg & ~BUTTON_MASK) == '0,
        "pressed bit set beyond the button count")
    `KEA_ASSERT_SAME(a_repeat_needs_held, clk, rst_n, take,
        (repeat_hits & ~held_m) == '0,
        "repeat event on a button that is not held")

endmodule

`default_nettype wire
